### src/urs_pkg.sv
// Shared types, constants and the echo conversion function for the ultrasonic ranging sequencer.
package urs_pkg;

  localparam int unsigned TimeW   = 16;
  localparam int unsigned PulseW  = 8;
  localparam int unsigned ThreshW = 9;
  localparam int unsigned EchoW   = 16;
  localparam int unsigned DistW   = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  // Echo time to centimeters: floor(us * 17 / 1000) = floor(floor(us * 17 / 8) / 125).
  // The division by 125 is a multiply by ceil(2^25 / 125) followed by a 25-bit shift.
  localparam int unsigned ScaledW = 21;
  localparam int unsigned QuotInW = ScaledW - 3;
  localparam int unsigned RecipW  = 19;
  localparam int unsigned RecipSh = 25;
  localparam logic [RecipW-1:0] Recip125 = RecipW'(268436);
  localparam int unsigned ProdW   = QuotInW + RecipW;

  localparam logic [TimeW-1:0]   TimeMax        = '1;
  localparam logic [TimeW-1:0]   PeriodReset    = TimeW'(100);
  localparam logic [PulseW-1:0]  PulseReset     = PulseW'(2);
  localparam logic [ThreshW-1:0] ThresholdReset = ThreshW'(15);

  localparam logic [CfgIdxW-1:0] REG_PERIOD    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_PULSE     = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD = CfgIdxW'(2);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [TimeW-1:0]   period_ms;
    logic [PulseW-1:0]  pulse_ms;
    logic [ThreshW-1:0] threshold_cm;
  } cfg_t;

  typedef struct packed {
    logic             ms_tick;
    logic             echo_seen;
    logic [DistW-1:0] echo_cm;
  } poll_t;

  typedef struct packed {
    logic             trigger_level;
    logic             distance_new;
    logic [DistW-1:0] distance_cm;
    logic             too_close;
  } result_t;

  function automatic logic [DistW-1:0] us_to_cm(input logic [EchoW-1:0] us);
    logic [ScaledW-1:0] scaled;
    logic [ProdW-1:0]   prod;
    scaled = {1'b0, us, 4'b0000} + {5'b00000, us};
    prod = {{RecipW{1'b0}}, scaled[ScaledW-1:3]} * {{QuotInW{1'b0}}, Recip125};
    return prod[RecipSh +: DistW];
  endfunction

endpackage

### src/urs_poll_if.sv
// Poll channel interface: one transaction per poll.
interface urs_poll_if;
  logic                        valid;
  logic                        ready;
  logic                        ms_tick;
  logic                        echo_seen;
  logic [urs_pkg::EchoW-1:0]   echo_us;

  modport source (output valid, output ms_tick, output echo_seen, output echo_us, input ready);
  modport sink   (input valid, input ms_tick, input echo_seen, input echo_us, output ready);
endinterface

### src/urs_result_if.sv
// Result channel interface: one transaction per poll result.
interface urs_result_if;
  logic                        valid;
  logic                        ready;
  logic                        trigger_level;
  logic                        distance_new;
  logic [urs_pkg::DistW-1:0]   distance_cm;
  logic                        too_close;

  modport source (output valid, output trigger_level, output distance_new,
                  output distance_cm, output too_close, input ready);
  modport sink   (input valid, input trigger_level, input distance_new,
                  input distance_cm, input too_close, output ready);
endinterface

### src/urs_cfg_if.sv
// Configuration write channel interface.
interface urs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [urs_pkg::CfgIdxW-1:0]   index;
  logic [urs_pkg::CfgDatW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/ultrasonic_ranging_sequencer.sv
// Top level of the ultrasonic ranging sequencer: trigger timing and echo-to-distance results.
// A poll accepted by the input stage is registered there, then its result is registered in the result stage.
// Throughput: one poll per cycle while the result channel is ready; the sequencer step is a single registered pass.
// The echo conversion multiplier sits in the input stage, the state update in the result stage.
// Synchronous active-high reset clears the sequencer to idle, zero distance and default registers.
// Configuration writes are always ready and take effect on the following cycle.
module ultrasonic_ranging_sequencer (
  input  logic          clk,
  input  logic          rst,
  urs_poll_if.sink      poll,
  urs_result_if.source  res,
  urs_cfg_if.sink       cfg
);

  urs_pkg::cfg_t    cfg_regs;
  urs_pkg::poll_t   conv_poll;
  urs_pkg::result_t step_res;
  logic             conv_valid;
  logic             step_ready;

  urs_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .wr_ready (cfg.ready),
    .cfg      (cfg_regs)
  );

  urs_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (poll.valid),
    .in_ready  (poll.ready),
    .ms_tick   (poll.ms_tick),
    .echo_seen (poll.echo_seen),
    .echo_us   (poll.echo_us),
    .out_valid (conv_valid),
    .out_ready (step_ready),
    .out_poll  (conv_poll)
  );

  urs_step u_step (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .in_valid  (conv_valid),
    .in_ready  (step_ready),
    .in_poll   (conv_poll),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_res   (step_res)
  );

  assign res.trigger_level = step_res.trigger_level;
  assign res.distance_new  = step_res.distance_new;
  assign res.distance_cm   = step_res.distance_cm;
  assign res.too_close     = step_res.too_close;

  // A fresh distance only comes out of the wait phase, where the trigger is already low.
  a_no_trigger_with_fresh: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.trigger_level && res.distance_new))
    else $error("trigger high on a result carrying a fresh distance");

  // The conversion never exceeds the distance of the longest echo.
  a_distance_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.distance_cm <= urs_pkg::DistW'(1114)))
    else $error("distance out of range");

  // A poll waiting in the input stage holds while the result stage is stalled.
  a_conv_hold: assert property (@(posedge clk) disable iff (rst)
    (conv_valid && !step_ready) |=> (conv_valid && $stable(conv_poll)))
    else $error("input stage lost or changed a stalled poll");

  // Reset empties the result stage.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res.valid)
    else $error("result valid right after reset");

endmodule

### src/urs_regs.sv
// Configuration register file for period, pulse length and distance threshold.
module urs_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_valid,
  input  logic [urs_pkg::CfgIdxW-1:0] wr_index,
  input  logic [urs_pkg::CfgDatW-1:0] wr_data,
  output logic                        wr_ready,
  output urs_pkg::cfg_t               cfg
);

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_ms    <= urs_pkg::PeriodReset;
      cfg.pulse_ms     <= urs_pkg::PulseReset;
      cfg.threshold_cm <= urs_pkg::ThresholdReset;
    end else if (wr_valid) begin
      case (wr_index)
        urs_pkg::REG_PERIOD:    cfg.period_ms    <= wr_data[urs_pkg::TimeW-1:0];
        urs_pkg::REG_PULSE:     cfg.pulse_ms     <= wr_data[urs_pkg::PulseW-1:0];
        urs_pkg::REG_THRESHOLD: cfg.threshold_cm <= wr_data[urs_pkg::ThreshW-1:0];
        default: ;
      endcase
    end
  end

endmodule

### src/urs_conv.sv
// Input stage: registers a poll and converts its echo time to centimeters.
module urs_conv (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      ms_tick,
  input  logic                      echo_seen,
  input  logic [urs_pkg::EchoW-1:0] echo_us,
  output logic                      out_valid,
  input  logic                      out_ready,
  output urs_pkg::poll_t            out_poll
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_poll.ms_tick   <= ms_tick;
      out_poll.echo_seen <= echo_seen;
      out_poll.echo_cm   <= urs_pkg::us_to_cm(echo_us);
    end
  end

endmodule

### src/urs_step.sv
// Sequencer state, one step per poll, and the registered result.
module urs_step (
  input  logic               clk,
  input  logic               rst,
  input  urs_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  urs_pkg::poll_t     in_poll,
  output logic               out_valid,
  input  logic               out_ready,
  output urs_pkg::result_t   out_res
);

  urs_pkg::phase_t              phase, phase_next;
  logic [urs_pkg::TimeW-1:0]    elapsed_ms, elapsed_ms_next;
  logic                         echo_pending, echo_pending_next;
  logic [urs_pkg::DistW-1:0]    echo_held, echo_held_next;
  logic [urs_pkg::DistW-1:0]    last_distance, last_distance_next;
  logic                         trigger_out, trigger_out_next;
  logic                         fresh;
  logic [urs_pkg::TimeW-1:0]    elapsed_tick;
  logic                         take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    elapsed_tick = elapsed_ms;
    if (in_poll.ms_tick && (elapsed_ms != urs_pkg::TimeMax)) begin
      elapsed_tick = elapsed_ms + urs_pkg::TimeW'(1);
    end
    elapsed_ms_next    = elapsed_tick;
    echo_pending_next  = echo_pending || in_poll.echo_seen;
    echo_held_next     = in_poll.echo_seen ? in_poll.echo_cm : echo_held;
    last_distance_next = last_distance;
    trigger_out_next   = trigger_out;
    phase_next         = phase;
    fresh              = 1'b0;

    case (phase)
      urs_pkg::PH_IDLE: begin
        if (elapsed_tick > cfg.period_ms) begin
          elapsed_ms_next  = '0;
          trigger_out_next = 1'b1;
          phase_next       = urs_pkg::PH_TRIG;
        end
      end
      urs_pkg::PH_TRIG: begin
        if (elapsed_tick > {{(urs_pkg::TimeW - urs_pkg::PulseW){1'b0}}, cfg.pulse_ms}) begin
          trigger_out_next = 1'b0;
          phase_next       = urs_pkg::PH_WAIT;
        end
      end
      urs_pkg::PH_WAIT: begin
        if (echo_pending_next) begin
          last_distance_next = echo_held_next;
          echo_pending_next  = 1'b0;
          fresh              = 1'b1;
          phase_next         = urs_pkg::PH_IDLE;
        end else if (elapsed_tick > cfg.period_ms) begin
          phase_next = urs_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_next = urs_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= urs_pkg::PH_IDLE;
      elapsed_ms    <= '0;
      echo_pending  <= 1'b0;
      echo_held     <= '0;
      last_distance <= '0;
      trigger_out   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        phase         <= phase_next;
        elapsed_ms    <= elapsed_ms_next;
        echo_pending  <= echo_pending_next;
        echo_held     <= echo_held_next;
        last_distance <= last_distance_next;
        trigger_out   <= trigger_out_next;
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res.trigger_level <= trigger_out_next;
      out_res.distance_new  <= fresh;
      out_res.distance_cm   <= last_distance_next;
      out_res.too_close     <= last_distance_next <
                               {{(urs_pkg::DistW - urs_pkg::ThreshW){1'b0}}, cfg.threshold_cm};
    end
  end

endmodule
